>>> src/efdf_pkg.sv
// Shared types and constants for the escaped frame deframer and filter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package efdf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEVICE_ADDRESS   = 3'd0;
  localparam logic [2:0] CFG_ESCAPE_BYTE      = 3'd1;
  localparam logic [2:0] CFG_END_CODE         = 3'd2;
  localparam logic [2:0] CFG_ZERO_CODE        = 3'd3;
  localparam logic [2:0] CFG_ONE_CODE         = 3'd4;
  localparam logic [2:0] CFG_EXPECTED_VERSION = 3'd5;
  localparam logic [2:0] CFG_COMMAND_CODE     = 3'd6;
  localparam logic [2:0] CFG_RESPONSE_CODE    = 3'd7;

  // Verdict codes.
  localparam logic [2:0] VERD_COMMAND  = 3'd0;
  localparam logic [2:0] VERD_RESPONSE = 3'd1;
  localparam logic [2:0] VERD_VERSION  = 3'd2;
  localparam logic [2:0] VERD_LENGTH   = 3'd3;
  localparam logic [2:0] VERD_ADDRESS  = 3'd4;
  localparam logic [2:0] VERD_TYPE     = 3'd5;
  localparam logic [2:0] VERD_OVERFLOW = 3'd6;
  localparam logic [2:0] VERD_BAD_ESC  = 3'd7;

  // Result item kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] escape_byte;
    logic [7:0] end_code;
    logic [7:0] zero_code;
    logic [7:0] one_code;
    logic [7:0] expected_version;
    logic [7:0] command_code;
    logic [7:0] response_code;
  } cfg_t;

  // What the front hands to the back for one classified link byte.
  typedef enum logic [1:0] {
    OP_DATA,
    OP_BAD_ESC,
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
    logic       last;
  } entry_t;

endpackage

>>> src/escaped_frame_deframer_filter.sv
// Escaped frame deframer with header filter: configuration registers, front, queue and back.
// Depends on efdf_pkg, efdf_front, efdf_queue and efdf_back.
// Throughput, when not stalled: one link byte per cycle; the front and the back each run at one byte per cycle.
// A result passes through a queue slot and then the output register after its byte's transfer.
// In a steady stream the input stalls once an output stall has filled the queue; the queue holds the
// byte taken as the output stall began. Reset clears the escape state, the frame state, the queue and the
// output valid, and restores every configuration register to its default.
module escaped_frame_deframer_filter
  import efdf_pkg::*;
#(
  parameter int MAX_FRAME   = 256,
  parameter int VERSION_POS = 0,
  parameter int LENGTH_POS  = 1,
  parameter int TYPE_POS    = 2,
  parameter int DEST_POS    = 3,
  parameter int BROADCAST   = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] link_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       item_kind_o,
  output logic [7:0] decoded_byte_o,
  output logic [8:0] byte_position_o,
  output logic [2:0] verdict_o
);

  cfg_t   cfg_q;
  logic   push, full, q_valid, q_pop;
  entry_t front_entry, q_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address   <= 8'd0;
      cfg_q.escape_byte      <= 8'd125;
      cfg_q.end_code         <= 8'd3;
      cfg_q.zero_code        <= 8'd4;
      cfg_q.one_code         <= 8'd5;
      cfg_q.expected_version <= 8'd1;
      cfg_q.command_code     <= 8'd0;
      cfg_q.response_code    <= 8'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEVICE_ADDRESS:   cfg_q.device_address   <= cfg_data_i;
        CFG_ESCAPE_BYTE:      cfg_q.escape_byte      <= cfg_data_i;
        CFG_END_CODE:         cfg_q.end_code         <= cfg_data_i;
        CFG_ZERO_CODE:        cfg_q.zero_code        <= cfg_data_i;
        CFG_ONE_CODE:         cfg_q.one_code         <= cfg_data_i;
        CFG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data_i;
        CFG_COMMAND_CODE:     cfg_q.command_code     <= cfg_data_i;
        CFG_RESPONSE_CODE:    cfg_q.response_code    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  efdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .link_byte_i  (link_byte_i),
    .buffer_end_i (buffer_end_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (front_entry)
  );

  efdf_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_entry)
  );

  efdf_back #(
    .MAX_FRAME   (MAX_FRAME),
    .VERSION_POS (VERSION_POS),
    .LENGTH_POS  (LENGTH_POS),
    .TYPE_POS    (TYPE_POS),
    .DEST_POS    (DEST_POS),
    .BROADCAST   (BROADCAST)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .decoded_byte_o  (decoded_byte_o),
    .byte_position_o (byte_position_o),
    .verdict_o       (verdict_o)
  );

endmodule

>>> src/efdf_front.sv
// Front end: accepts link bytes, strips escape stuffing and classifies each byte.
// Depends on efdf_pkg; feeds efdf_queue.
module efdf_front
  import efdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] link_byte_i,
  input  logic       buffer_end_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic esc_pending_q, esc_pending_d;
  logic accept;
  logic keep;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  always_comb begin
    esc_pending_d = esc_pending_q;
    keep          = 1'b1;
    entry_o.op    = OP_DATA;
    entry_o.value = link_byte_i;
    entry_o.last  = buffer_end_i;
    if (esc_pending_q) begin
      esc_pending_d = 1'b0;
      if (link_byte_i == cfg_i.end_code) begin
        entry_o.op = OP_END;
      end else if (link_byte_i == cfg_i.zero_code) begin
        entry_o.value = 8'd0;
      end else if (link_byte_i == cfg_i.one_code) begin
        entry_o.value = 8'd1;
      end else begin
        entry_o.op = OP_BAD_ESC;
      end
    end else if (link_byte_i == cfg_i.escape_byte) begin
      // An escape that ends the buffer can never get its code.
      if (buffer_end_i) begin
        entry_o.op = OP_BAD_ESC;
      end else begin
        esc_pending_d = 1'b1;
        keep          = 1'b0;
      end
    end
  end

  assign push_o = accept & keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pending_q <= 1'b0;
    end else if (accept) begin
      esc_pending_q <= esc_pending_d;
    end
  end

endmodule

>>> src/efdf_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on efdf_pkg for the entry type.
module efdf_queue
  import efdf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output entry_t entry_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/efdf_back.sv
// Back end: frame counting, header capture, verdict and the output register.
// Depends on efdf_pkg; drains efdf_queue.
module efdf_back
  import efdf_pkg::*;
#(
  parameter int MAX_FRAME   = 256,
  parameter int VERSION_POS = 0,
  parameter int LENGTH_POS  = 1,
  parameter int TYPE_POS    = 2,
  parameter int DEST_POS    = 3,
  parameter int BROADCAST   = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       item_kind_o,
  output logic [7:0] decoded_byte_o,
  output logic [8:0] byte_position_o,
  output logic [2:0] verdict_o
);

  localparam logic [8:0] MaxCnt     = 9'(MAX_FRAME);
  localparam logic [8:0] VersionPos = 9'(VERSION_POS);
  localparam logic [8:0] LengthPos  = 9'(LENGTH_POS);
  localparam logic [8:0] TypePos    = 9'(TYPE_POS);
  localparam logic [8:0] DestPos    = 9'(DEST_POS);
  localparam logic [7:0] Bcast      = 8'(BROADCAST);

  logic [8:0] cnt_q, cnt_d;
  logic [7:0] ver_q, ver_d, len_q, len_d, dst_q, dst_d, typ_q, typ_d;
  logic       ovf_q, ovf_d, esc_q, esc_d;

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic [8:0] pos_q;
  logic [2:0] verd_q;

  logic       emit_verdict, emit_data;
  logic [2:0] verd;

  assign q_pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    cnt_d        = cnt_q;
    ver_d        = ver_q;
    len_d        = len_q;
    dst_d        = dst_q;
    typ_d        = typ_q;
    ovf_d        = ovf_q;
    esc_d        = esc_q;
    emit_verdict = 1'b0;
    emit_data    = 1'b0;
    case (q_entry_i.op)
      OP_END: begin
        emit_verdict = 1'b1;
      end
      OP_BAD_ESC: begin
        esc_d        = 1'b1;
        emit_verdict = q_entry_i.last;
      end
      OP_DATA: begin
        emit_verdict = q_entry_i.last;
        if (cnt_q >= MaxCnt) begin
          ovf_d = 1'b1;
        end else begin
          if (cnt_q == VersionPos) ver_d = q_entry_i.value;
          if (cnt_q == LengthPos)  len_d = q_entry_i.value;
          if (cnt_q == DestPos)    dst_d = q_entry_i.value;
          if (cnt_q == TypePos)    typ_d = q_entry_i.value;
          cnt_d     = cnt_q + 9'd1;
          emit_data = ~q_entry_i.last;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks in priority order, on the frame state after this byte.
  always_comb begin
    if (esc_d) begin
      verd = VERD_BAD_ESC;
    end else if (ovf_d) begin
      verd = VERD_OVERFLOW;
    end else if (ver_d != cfg_i.expected_version) begin
      verd = VERD_VERSION;
    end else if (cnt_d != {1'b0, len_d}) begin
      verd = VERD_LENGTH;
    end else if (dst_d != cfg_i.device_address && dst_d != Bcast) begin
      verd = VERD_ADDRESS;
    end else if (typ_d == cfg_i.command_code) begin
      verd = VERD_COMMAND;
    end else if (typ_d == cfg_i.response_code) begin
      verd = VERD_RESPONSE;
    end else begin
      verd = VERD_TYPE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ver_q       <= '0;
      len_q       <= '0;
      dst_q       <= '0;
      typ_q       <= '0;
      ovf_q       <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        if (emit_verdict) begin
          cnt_q <= '0;
          ver_q <= '0;
          len_q <= '0;
          dst_q <= '0;
          typ_q <= '0;
          ovf_q <= 1'b0;
          esc_q <= 1'b0;
        end else begin
          cnt_q <= cnt_d;
          ver_q <= ver_d;
          len_q <= len_d;
          dst_q <= dst_d;
          typ_q <= typ_d;
          ovf_q <= ovf_d;
          esc_q <= esc_d;
        end
        out_valid_q <= emit_verdict | emit_data;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (emit_verdict) begin
        kind_q <= KIND_VERDICT;
        byte_q <= 8'd0;
        pos_q  <= cnt_d;
        verd_q <= verd;
      end else begin
        kind_q <= KIND_DATA;
        byte_q <= q_entry_i.value;
        pos_q  <= cnt_q;
        verd_q <= VERD_COMMAND;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = kind_q;
  assign decoded_byte_o  = byte_q;
  assign byte_position_o = pos_q;
  assign verdict_o       = verd_q;

endmodule
